// ===== rtl/core/gmgf_pkg.sv =====
// Shared widths, codes and pipeline tag types for the Gauss-Markov grid field block.
package gmgf_pkg;

    localparam int NOISE_W    = 16;
    localparam int VAL_W      = 32;
    localparam int COEF_W     = 15;
    localparam int GAIN_W     = 24;
    localparam int SIZE_W     = 11;
    localparam int OUT_IDX_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_R      = 3'd0,
        CFG_COEF_S      = 3'd1,
        CFG_COEF_RS     = 3'd2,
        CFG_NOISE_GAIN  = 3'd3,
        CFG_CORNER_GAIN = 3'd4,
        CFG_GRID_ROWS   = 3'd5,
        CFG_GRID_COLS   = 3'd6
    } t_cfg_idx;

    // Which recurrence a cell uses
    typedef enum logic [1:0] {
        KIND_CORNER = 2'd0,
        KIND_ROW0   = 2'd1,
        KIND_COL0   = 2'd2,
        KIND_INNER  = 2'd3
    } t_kind;

    // Output bookkeeping that travels alongside a cell
    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [OUT_IDX_W-1:0] orow;
        logic [OUT_IDX_W-1:0] ocol;
    } t_tag;

endpackage

// ===== rtl/core/gmgf_calc.sv =====
// Three-stage multiply-accumulate datapath: products, partial sum, feedback term and rounding.
module gmgf_calc (
    input  logic                                 i_clk,
    input  logic signed [gmgf_pkg::NOISE_W-1:0]  i_noise,
    input  logic signed [gmgf_pkg::VAL_W-1:0]    i_left,
    input  gmgf_pkg::t_kind                      i_kind,
    input  logic                                 i_s1_go,
    input  logic                                 i_s2_go,
    input  logic                                 i_s3_go,
    input  logic        [gmgf_pkg::COEF_W-1:0]   i_coef_r,
    input  logic        [gmgf_pkg::COEF_W-1:0]   i_coef_s,
    input  logic        [gmgf_pkg::COEF_W-1:0]   i_coef_rs,
    input  logic        [gmgf_pkg::GAIN_W-1:0]   i_noise_gain,
    input  logic        [gmgf_pkg::GAIN_W-1:0]   i_corner_gain,
    output logic signed [gmgf_pkg::VAL_W-1:0]    o_val
);

    localparam int PN_W  = gmgf_pkg::NOISE_W + gmgf_pkg::GAIN_W + 1;
    localparam int PC_W  = gmgf_pkg::COEF_W + 1 + gmgf_pkg::VAL_W;
    localparam int ACC_W = PC_W + 2;

    function automatic logic signed [gmgf_pkg::VAL_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] a
    );
        logic [ACC_W-1:0]  b;
        logic [ACC_W-16:0] sh;
        logic              in_range;
        b  = a + {{(ACC_W-15){1'b0}}, 1'b1, 14'd0};
        // floor shift by 15 is the upper slice
        sh = b[ACC_W-1:15];
        in_range = (&sh[ACC_W-16:gmgf_pkg::VAL_W-1]) || !(|sh[ACC_W-16:gmgf_pkg::VAL_W-1]);
        if (in_range) begin
            return sh[gmgf_pkg::VAL_W-1:0];
        end else if (sh[ACC_W-16]) begin
            return {1'b1, {(gmgf_pkg::VAL_W-1){1'b0}}};
        end else begin
            return {1'b0, {(gmgf_pkg::VAL_W-1){1'b1}}};
        end
    endfunction

    // stage 1 products
    logic        [gmgf_pkg::GAIN_W-1:0] gain;
    logic signed [PN_W-1:0]             n_p_noise;
    logic signed [PC_W-1:0]             n_p_left;
    logic signed [PC_W-1:0]             n_p_diag;

    logic signed [PN_W-1:0]             r_p_noise;
    logic signed [PC_W-1:0]             r_p_left;
    logic signed [PC_W-1:0]             r_p_diag;
    gmgf_pkg::t_kind                    r_kind2;
    logic signed [gmgf_pkg::VAL_W-1:0]  r_diag;

    // stage 2 partial sum
    logic signed [ACC_W-1:0]            noise_term;
    logic signed [ACC_W-1:0]            left_term;
    logic signed [ACC_W-1:0]            diag_term;
    logic signed [ACC_W-1:0]            n_part;
    logic signed [ACC_W-1:0]            r_part;
    logic                               r_use_above;

    // stage 3 feedback
    logic signed [PC_W-1:0]             p_above;
    logic signed [ACC_W-1:0]            acc;
    logic signed [gmgf_pkg::VAL_W-1:0]  r_above;

    assign gain      = (i_kind == gmgf_pkg::KIND_CORNER) ? i_corner_gain : i_noise_gain;
    assign n_p_noise = i_noise * $signed({1'b0, gain});
    assign n_p_left  = $signed({1'b0, i_coef_r}) * i_left;
    assign n_p_diag  = $signed({1'b0, i_coef_rs}) * r_diag;

    always_ff @(posedge i_clk) begin
        if (i_s1_go) begin
            r_p_noise <= n_p_noise;
            r_p_left  <= n_p_left;
            r_p_diag  <= n_p_diag;
            r_kind2   <= i_kind;
            r_diag    <= i_left;
        end
    end

    assign noise_term = {{(ACC_W-PN_W){r_p_noise[PN_W-1]}}, r_p_noise} <<< 3;
    assign left_term  = {{(ACC_W-PC_W){r_p_left[PC_W-1]}}, r_p_left};
    assign diag_term  = {{(ACC_W-PC_W){r_p_diag[PC_W-1]}}, r_p_diag};

    always_comb begin
        unique case (r_kind2)
            gmgf_pkg::KIND_CORNER: n_part = noise_term;
            gmgf_pkg::KIND_ROW0:   n_part = noise_term + left_term;
            gmgf_pkg::KIND_COL0:   n_part = noise_term;
            gmgf_pkg::KIND_INNER:  n_part = noise_term + left_term - diag_term;
            default:               n_part = noise_term;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_s2_go) begin
            r_part      <= n_part;
            r_use_above <= (r_kind2 == gmgf_pkg::KIND_COL0) || (r_kind2 == gmgf_pkg::KIND_INNER);
        end
    end

    // the cell above is the previous cell through this stage
    assign p_above = $signed({1'b0, i_coef_s}) * r_above;
    assign acc     = r_part + (r_use_above ?
                     {{(ACC_W-PC_W){p_above[PC_W-1]}}, p_above} : {ACC_W{1'b0}});
    assign o_val   = round_sat(acc);

    always_ff @(posedge i_clk) begin
        if (i_s3_go) begin
            r_above <= o_val;
        end
    end

endmodule

// ===== rtl/core/gauss_markov_grid_field.sv =====
// Top level of the Gauss-Markov grid field: position control, line store and output register.
// One noise beat per cell, column-major. Each beat enters a four-register path: line-store read
// on the accept, products, partial sum, then the upper-cell term with rounding and saturation
// into the output register. Cells flow at one per cycle while grid_rows is 4 or more and the
// output is not held back by i_err_ready; with 2 or 3 rows a beat waits until no cell of the same
// row is still in the three arithmetic stages, since its left neighbour must first be written back
// to the line store (single read port, single write port, one line of MAX_ROWS words). No
// clearing pass follows reset. Only cells at least MARGIN from every edge leave the block.
module gauss_markov_grid_field #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024,
    parameter int MARGIN   = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic        [gmgf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [gmgf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                  i_noise_valid,
    output logic                                  o_noise_ready,
    input  logic signed [gmgf_pkg::NOISE_W-1:0]   i_noise_sample,
    output logic                                  o_err_valid,
    input  logic                                  i_err_ready,
    output logic signed [gmgf_pkg::VAL_W-1:0]     o_error_value,
    output logic        [gmgf_pkg::OUT_IDX_W-1:0] o_out_row,
    output logic        [gmgf_pkg::OUT_IDX_W-1:0] o_out_col,
    output logic                                  o_last_cell
);

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int POS_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int CMP_W  = ((POS_W + 1 > gmgf_pkg::SIZE_W) ? POS_W + 1 : gmgf_pkg::SIZE_W) + 1;
    localparam logic [CMP_W-1:0] MARG    = CMP_W'(MARGIN);
    localparam logic [CMP_W-1:0] MARG2   = CMP_W'(2 * MARGIN);
    localparam logic [CMP_W-1:0] MIN_SZ  = CMP_W'(2);
    localparam logic [CMP_W-1:0] MAX_R   = CMP_W'(MAX_ROWS);
    localparam logic [CMP_W-1:0] MAX_C   = CMP_W'(MAX_COLS);
    localparam logic [CMP_W-1:0] ONE     = CMP_W'(1);

    // configuration
    logic [gmgf_pkg::COEF_W-1:0] r_coef_r;
    logic [gmgf_pkg::COEF_W-1:0] r_coef_s;
    logic [gmgf_pkg::COEF_W-1:0] r_coef_rs;
    logic [gmgf_pkg::GAIN_W-1:0] r_noise_gain;
    logic [gmgf_pkg::GAIN_W-1:0] r_corner_gain;
    logic [gmgf_pkg::SIZE_W-1:0] r_grid_rows;
    logic [gmgf_pkg::SIZE_W-1:0] r_grid_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_r      <= 15'd29491;
            r_coef_s      <= 15'd29491;
            r_coef_rs     <= 15'd26542;
            r_noise_gain  <= 24'd65536;
            r_corner_gain <= 24'd65536;
            r_grid_rows   <= 11'd16;
            r_grid_cols   <= 11'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gmgf_pkg::CFG_COEF_R:      r_coef_r      <= i_cfg_data[gmgf_pkg::COEF_W-1:0];
                gmgf_pkg::CFG_COEF_S:      r_coef_s      <= i_cfg_data[gmgf_pkg::COEF_W-1:0];
                gmgf_pkg::CFG_COEF_RS:     r_coef_rs     <= i_cfg_data[gmgf_pkg::COEF_W-1:0];
                gmgf_pkg::CFG_NOISE_GAIN:  r_noise_gain  <= i_cfg_data[gmgf_pkg::GAIN_W-1:0];
                gmgf_pkg::CFG_CORNER_GAIN: r_corner_gain <= i_cfg_data[gmgf_pkg::GAIN_W-1:0];
                gmgf_pkg::CFG_GRID_ROWS:   r_grid_rows   <= i_cfg_data[gmgf_pkg::SIZE_W-1:0];
                gmgf_pkg::CFG_GRID_COLS:   r_grid_cols   <= i_cfg_data[gmgf_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped grid size
    logic [CMP_W-1:0] rows_ext;
    logic [CMP_W-1:0] cols_ext;
    logic [CMP_W-1:0] rows_c;
    logic [CMP_W-1:0] cols_c;

    assign rows_ext = CMP_W'(r_grid_rows);
    assign cols_ext = CMP_W'(r_grid_cols);
    assign rows_c   = (rows_ext < MIN_SZ) ? MIN_SZ : ((rows_ext > MAX_R) ? MAX_R : rows_ext);
    assign cols_c   = (cols_ext < MIN_SZ) ? MIN_SZ : ((cols_ext > MAX_C) ? MAX_C : cols_ext);

    // position of the next cell
    logic [ROW_W-1:0] r_row_cnt;
    logic [COL_W-1:0] r_col_cnt;
    logic [CMP_W-1:0] row_e;
    logic [CMP_W-1:0] col_e;
    logic [CMP_W-1:0] row_inc;
    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] row_off;
    logic [CMP_W-1:0] col_off;
    gmgf_pkg::t_kind  kind0;
    gmgf_pkg::t_tag   tag0;

    assign row_e   = CMP_W'(r_row_cnt);
    assign col_e   = CMP_W'(r_col_cnt);
    assign row_inc = row_e + ONE;
    assign col_inc = col_e + ONE;
    assign row_off = row_e - MARG;
    assign col_off = col_e - MARG;

    always_comb begin
        priority if (r_row_cnt == '0 && r_col_cnt == '0) begin
            kind0 = gmgf_pkg::KIND_CORNER;
        end else if (r_row_cnt == '0) begin
            kind0 = gmgf_pkg::KIND_ROW0;
        end else if (r_col_cnt == '0) begin
            kind0 = gmgf_pkg::KIND_COL0;
        end else begin
            kind0 = gmgf_pkg::KIND_INNER;
        end
    end

    always_comb begin
        tag0.emit = (rows_c > MARG2) && (cols_c > MARG2) &&
                    (row_e >= MARG) && (row_e + MARG < rows_c) &&
                    (col_e >= MARG) && (col_e + MARG < cols_c);
        tag0.last = tag0.emit &&
                    (row_e + MARG + ONE == rows_c) && (col_e + MARG + ONE == cols_c);
        tag0.orow = row_off[gmgf_pkg::OUT_IDX_W-1:0];
        tag0.ocol = col_off[gmgf_pkg::OUT_IDX_W-1:0];
    end

    // pipeline control
    logic                                r_v1;
    logic                                r_v2;
    logic                                r_v3;
    logic [ROW_W-1:0]                    r_row1;
    logic [ROW_W-1:0]                    r_row2;
    logic [ROW_W-1:0]                    r_row3;
    gmgf_pkg::t_tag                      r_tag1;
    gmgf_pkg::t_tag                      r_tag2;
    gmgf_pkg::t_tag                      r_tag3;
    gmgf_pkg::t_kind                     r_kind1;
    logic signed [gmgf_pkg::NOISE_W-1:0] r_noise1;
    logic signed [gmgf_pkg::VAL_W-1:0]   r_rd;
    logic signed [gmgf_pkg::VAL_W-1:0]   r_line [MAX_ROWS];

    logic                                out_free;
    logic                                s3_go;
    logic                                s3_free;
    logic                                s2_go;
    logic                                s2_free;
    logic                                s1_go;
    logic                                s1_free;
    logic                                hazard;
    logic                                acc_beat;
    logic signed [gmgf_pkg::VAL_W-1:0]   val3;

    logic                                r_out_valid;
    logic signed [gmgf_pkg::VAL_W-1:0]   r_out_val;
    gmgf_pkg::t_tag                      r_out_tag;

    assign out_free = !r_out_valid || i_err_ready;
    assign s3_go    = r_v3 && (!r_tag3.emit || out_free);
    assign s3_free  = !r_v3 || s3_go;
    assign s2_go    = r_v2 && s3_free;
    assign s2_free  = !r_v2 || s2_go;
    assign s1_go    = r_v1 && s2_free;
    assign s1_free  = !r_v1 || s1_go;

    // hold a beat while its row still has a cell in flight
    assign hazard   = (r_v1 && r_row1 == r_row_cnt) ||
                      (r_v2 && r_row2 == r_row_cnt) ||
                      (r_v3 && r_row3 == r_row_cnt);

    assign o_noise_ready = s1_free && !hazard;
    assign acc_beat      = i_noise_valid && o_noise_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (acc_beat) begin
            if (row_inc >= rows_c) begin
                r_row_cnt <= '0;
                if (col_inc >= cols_c) begin
                    r_col_cnt <= '0;
                end else begin
                    r_col_cnt <= col_inc[COL_W-1:0];
                end
            end else begin
                r_row_cnt <= row_inc[ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (acc_beat) begin
                r_v1 <= 1'b1;
            end else if (s1_go) begin
                r_v1 <= 1'b0;
            end
            if (s1_go) begin
                r_v2 <= 1'b1;
            end else if (s2_go) begin
                r_v2 <= 1'b0;
            end
            if (s2_go) begin
                r_v3 <= 1'b1;
            end else if (s3_go) begin
                r_v3 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_beat) begin
            r_row1   <= r_row_cnt;
            r_tag1   <= tag0;
            r_kind1  <= kind0;
            r_noise1 <= i_noise_sample;
        end
        if (s1_go) begin
            r_row2 <= r_row1;
            r_tag2 <= r_tag1;
        end
        if (s2_go) begin
            r_row3 <= r_row2;
            r_tag3 <= r_tag2;
        end
    end

    // line store: read the left neighbour on the beat, write back on retire
    always_ff @(posedge i_clk) begin
        if (acc_beat) begin
            r_rd <= r_line[r_row_cnt];
        end
        if (s3_go) begin
            r_line[r_row3] <= val3;
        end
    end

    gmgf_calc u_calc (
        .i_clk         (i_clk),
        .i_noise       (r_noise1),
        .i_left        (r_rd),
        .i_kind        (r_kind1),
        .i_s1_go       (s1_go),
        .i_s2_go       (s2_go),
        .i_s3_go       (s3_go),
        .i_coef_r      (r_coef_r),
        .i_coef_s      (r_coef_s),
        .i_coef_rs     (r_coef_rs),
        .i_noise_gain  (r_noise_gain),
        .i_corner_gain (r_corner_gain),
        .o_val         (val3)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s3_go && r_tag3.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_err_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_go && r_tag3.emit) begin
            r_out_val <= val3;
            r_out_tag <= r_tag3;
        end
    end

    assign o_err_valid   = r_out_valid;
    assign o_error_value = r_out_val;
    assign o_out_row     = r_out_tag.orow;
    assign o_out_col     = r_out_tag.ocol;
    assign o_last_cell   = r_out_tag.last;

    // cells in flight always sit on distinct rows
    a_rows_12: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2) |-> (r_row1 != r_row2))
        else $error("two cells of one row in stages 1 and 2");
    a_rows_13: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v3) |-> (r_row1 != r_row3))
        else $error("two cells of one row in stages 1 and 3");
    a_rows_23: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_v3) |-> (r_row2 != r_row3))
        else $error("two cells of one row in stages 2 and 3");
    a_last_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_tag1.last) |-> r_tag1.emit)
        else $error("last flag on a cell outside the cropped grid");
    a_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s3_go && r_tag3.emit) |=> (o_err_valid && o_error_value == $past(val3)))
        else $error("retired result not presented");

endmodule
